// File: design/hue_saturation_picker_colour_top_assert.svh
// Assertion macros for the colour picker engine.
// Both forms are sampled on the rising clock and are off while reset is held.
`ifndef HUE_SATURATION_PICKER_COLOUR_TOP_ASSERT_SVH
`define HUE_SATURATION_PICKER_COLOUR_TOP_ASSERT_SVH

// Same-cycle implication
`define HSP_CHK_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hsp check failed");

// Next-cycle implication
`define HSP_CHK_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hsp check failed");

`endif

// File: design/hsp_pkg.sv
package hsp_pkg;

    // Field and register widths
    localparam int CRD_W          = 16;
    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_W          = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int CH_W           = 8;
    localparam int COL_W          = 3 * CH_W;
    localparam int QUO_W          = 11;               // hue quotient reaches 6*255
    localparam int NUM_W          = CFG_W + QUO_W;    // dividend of the serial divider

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y = 2'd2;

    localparam logic [CFG_W-1:0] WIDTH_RST = 12'd256;
    localparam logic [COL_W-1:0] MASK_R    = 24'hFF0000;
    localparam logic [COL_W-1:0] MASK_G    = 24'h00FF00;
    localparam logic [COL_W-1:0] MASK_B    = 24'h0000FF;
    localparam logic [COL_W-1:0] HUE_RST   = MASK_R;
    localparam logic [CH_W-1:0]  CH_MAX    = 8'hFF;

    // Sextant span and hue numerator scale (6 * 255)
    localparam logic [QUO_W-1:0] SEXT_SPAN = 11'd255;
    localparam logic [CFG_W-1:0] HUE_SCALE = CFG_W'(6 * 255);

    // Channel indexes
    localparam logic [1:0] CH_R = 2'd0;
    localparam logic [1:0] CH_G = 2'd1;
    localparam logic [1:0] CH_B = 2'd2;

    // Colour request divide jobs
    localparam logic [2:0] JOB_SAT_MID = 3'd0;
    localparam logic [2:0] JOB_SAT_LO  = 3'd1;
    localparam logic [2:0] JOB_BRT_R   = 3'd2;
    localparam logic [2:0] JOB_BRT_G   = 3'd3;
    localparam logic [2:0] JOB_BRT_B   = 3'd4;

    typedef struct packed {
        logic start;
        logic wide;     // full hue quotient rather than one channel
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    typedef struct packed {
        logic [1:0] hi;
        logic [1:0] lo;
        logic [1:0] mid;
    } t_roles;

    function automatic logic [CH_W-1:0] ch_of(input logic [COL_W-1:0] c,
                                              input logic [1:0] idx);
        logic [CH_W-1:0] v;
        case (idx)
            CH_R:    v = c[23:16];
            CH_G:    v = c[15:8];
            default: v = c[7:0];
        endcase
        return v;
    endfunction

    function automatic logic [COL_W-1:0] ch_put(input logic [COL_W-1:0] c,
                                                input logic [1:0] idx,
                                                input logic [CH_W-1:0] v);
        logic [COL_W-1:0] r;
        r = c;
        case (idx)
            CH_R:    r[23:16] = v;
            CH_G:    r[15:8]  = v;
            default: r[7:0]   = v;
        endcase
        return r;
    endfunction

    // Highest, lowest and middle channel, ties settled in fixed order
    function automatic t_roles roles_of(input logic [COL_W-1:0] c);
        t_roles rl;
        rl.hi  = (ch_of(c, CH_R) > ch_of(c, CH_G)) ? CH_R : CH_G;
        rl.hi  = (ch_of(c, rl.hi) > ch_of(c, CH_B)) ? rl.hi : CH_B;
        rl.lo  = (ch_of(c, CH_R) < ch_of(c, CH_G)) ? CH_R : CH_G;
        rl.lo  = (ch_of(c, rl.lo) < ch_of(c, CH_B)) ? rl.lo : CH_B;
        if (rl.hi == CH_R || rl.lo == CH_R) begin
            rl.mid = (rl.hi == CH_B || rl.lo == CH_B) ? CH_G : CH_B;
        end else begin
            rl.mid = CH_R;
        end
        return rl;
    endfunction

    // Hue from q = floor(1530*x/W): sextant = q/255 capped at 5, ramp = remainder
    function automatic logic [COL_W-1:0] hue_of(input logic [QUO_W-1:0] q);
        logic [2:0]       s;
        logic [QUO_W-1:0] base;
        logic [CH_W-1:0]  rem;
        logic [COL_W-1:0] c;
        if (q >= QUO_W'(5 * SEXT_SPAN)) begin
            s = 3'd5;
        end else if (q >= QUO_W'(4 * SEXT_SPAN)) begin
            s = 3'd4;
        end else if (q >= QUO_W'(3 * SEXT_SPAN)) begin
            s = 3'd3;
        end else if (q >= QUO_W'(2 * SEXT_SPAN)) begin
            s = 3'd2;
        end else if (q >= SEXT_SPAN) begin
            s = 3'd1;
        end else begin
            s = 3'd0;
        end
        base = QUO_W'(s * SEXT_SPAN);
        rem  = CH_W'(q - base);
        case (s)
            3'd0:    c = MASK_R | {8'h00, rem, 8'h00};
            3'd1:    c = MASK_G | {CH_MAX - rem, 16'h0000};
            3'd2:    c = MASK_G | {16'h0000, rem};
            3'd3:    c = MASK_B | {8'h00, CH_MAX - rem, 8'h00};
            3'd4:    c = MASK_B | {rem, 16'h0000};
            default: c = MASK_R | {16'h0000, CH_MAX - rem};
        endcase
        return c;
    endfunction

endpackage

// File: design/hsp_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// The dividend is known to give a quotient of QUO_W bits (wide) or CH_W bits.
module hsp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hsp_pkg::t_div_ctl          i_ctl,
    input  logic [hsp_pkg::NUM_W-1:0]  i_num,
    input  logic [hsp_pkg::CFG_W-1:0]  i_den,
    output hsp_pkg::t_div_sts          o_sts,
    output logic [hsp_pkg::QUO_W-1:0]  o_quot
);
    import hsp_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [CFG_W-1:0] r_rem;
    logic [QUO_W-1:0] r_sh;     // dividend bits out at the top, quotient bits in below

    logic [CFG_W:0]   w_trial;
    logic             w_ge;
    logic [CFG_W-1:0] n_rem;

    // One trial subtraction
    assign w_trial = {r_rem, r_sh[QUO_W-1]};
    assign w_ge    = (w_trial >= {1'b0, i_den});
    assign n_rem   = w_ge ? CFG_W'(w_trial - {1'b0, i_den}) : w_trial[CFG_W-1:0];

    // Step counter and status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.wide ? CNT_W'(QUO_W) : CNT_W'(CH_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and shift register
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            if (i_ctl.wide) begin
                r_rem <= i_num[NUM_W-1:QUO_W];
                r_sh  <= i_num[QUO_W-1:0];
            end else begin
                r_rem <= i_num[CH_W+CFG_W-1:CH_W];
                r_sh  <= {i_num[CH_W-1:0], {(QUO_W-CH_W){1'b0}}};
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_sh  <= {r_sh[QUO_W-2:0], w_ge};
        end
    end

    assign o_sts  = '{busy: r_busy, done: r_done};
    assign o_quot = r_sh;

endmodule

// File: design/hue_saturation_picker_colour_top.sv
// Channel   Signals                              Payload
// input     i_in_valid / o_in_ready              i_req_type, i_pos_x, i_pos_y
// output    o_out_valid / i_out_ready            o_out_colour
// config    i_cfg_we, i_cfg_idx                  i_cfg_data (12 bits)
//
// A hue request uses one division; a colour request uses five, one per job.
// Both run through the shared bit-serial divider: 11 steps for the hue, 8 steps for
// each of the five colour divisions, plus multiply and hand-over cycles around each.
// One item is worked on at a time; a new one is taken while the last result waits.
// A stalled output holds the next result in the working register until it drains.
// Reset is synchronous: width 256, origins 0, current hue pure red.
`include "hue_saturation_picker_colour_top_assert.svh"

module hue_saturation_picker_colour_top #(
    parameter int COORD_BITS = hsp_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hsp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hsp_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic [hsp_pkg::CRD_W-1:0]     i_pos_x,
    input  logic [hsp_pkg::CRD_W-1:0]     i_pos_y,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [hsp_pkg::COL_W-1:0]     o_out_colour
);
    import hsp_pkg::*;

    localparam int SHIFT = CRD_W - COORD_BITS;

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MUL_A    = 3'd1;
    localparam logic [2:0] S_MUL_B    = 3'd2;
    localparam logic [2:0] S_SUB      = 3'd3;
    localparam logic [2:0] S_DIV_GO   = 3'd4;
    localparam logic [2:0] S_DIV_WAIT = 3'd5;
    localparam logic [2:0] S_OUT      = 3'd6;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_org_x;
    logic [CFG_W-1:0] r_org_y;
    logic [COL_W-1:0] r_hue;
    logic             r_out_valid;
    logic [COL_W-1:0] r_out_colour;

    logic             r_is_col;
    logic [CFG_W-1:0] r_x;
    logic [CFG_W-1:0] r_y;
    logic [COL_W-1:0] r_ch;
    logic [COL_W-1:0] r_res;
    logic [2:0]       r_job;
    logic [NUM_W-1:0] r_acc;
    logic [NUM_W-1:0] r_prd;

    logic             w_accept;
    logic             w_out_load;
    logic [CRD_W-1:0] w_sx_raw;
    logic [CRD_W-1:0] w_sy_raw;
    logic [CRD_W-1:0] w_sx;
    logic [CRD_W-1:0] w_sy;
    logic [CRD_W:0]   w_dx;
    logic [CRD_W:0]   w_dy;
    logic [CFG_W-1:0] w_x_hue;
    logic [CFG_W-1:0] w_x_col;
    logic [CFG_W-1:0] w_y_off;
    logic [CFG_W-1:0] w_y;

    t_roles           w_roles;
    logic [1:0]       w_sat_idx;
    logic [2:0]       w_job_off;
    logic [1:0]       w_brt_idx;
    logic [CH_W-1:0]  w_hv;
    logic [CH_W-1:0]  w_cv;
    logic [CH_W-1:0]  w_bv;
    logic [CFG_W-1:0] w_mul_a;
    logic [CFG_W-1:0] w_mul_b;
    logic [2*CFG_W-1:0] w_prod;

    t_div_ctl         w_div_ctl;
    t_div_sts         w_div_sts;
    logic [QUO_W-1:0] w_quot;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // Sign-extend the low COORD_BITS of each coordinate
    assign w_sx_raw = i_pos_x << SHIFT;
    assign w_sy_raw = i_pos_y << SHIFT;
    assign w_sx     = $signed(w_sx_raw) >>> SHIFT;
    assign w_sy     = $signed(w_sy_raw) >>> SHIFT;

    // Offsets from the picker origin, 17-bit two's complement
    assign w_dx = {w_sx[CRD_W-1], w_sx} - {{(CRD_W-CFG_W+1){1'b0}}, r_org_x};
    assign w_dy = {w_sy[CRD_W-1], w_sy} - {{(CRD_W-CFG_W+1){1'b0}}, r_org_y};

    // Clamping: hue x to 0..W, colour x and y offset to 0..W-1, brightness = W - y offset
    always_comb begin
        if (w_dx[CRD_W]) begin
            w_x_hue = '0;
            w_x_col = '0;
        end else begin
            w_x_hue = (w_dx[CRD_W-1:0] > {{(CRD_W-CFG_W){1'b0}}, r_width}) ?
                      r_width : w_dx[CFG_W-1:0];
            w_x_col = (w_dx[CRD_W-1:0] >= {{(CRD_W-CFG_W){1'b0}}, r_width}) ?
                      r_width - CFG_W'(1) : w_dx[CFG_W-1:0];
        end
        if (w_dy[CRD_W]) begin
            w_y_off = '0;
        end else begin
            w_y_off = (w_dy[CRD_W-1:0] >= {{(CRD_W-CFG_W){1'b0}}, r_width}) ?
                      r_width - CFG_W'(1) : w_dy[CFG_W-1:0];
        end
        w_y = r_width - w_y_off;
    end

    // Channel roles come from the stored hue, which a colour request leaves alone
    assign w_roles   = roles_of(r_hue);
    assign w_sat_idx = (r_job == JOB_SAT_MID) ? w_roles.mid : w_roles.lo;
    assign w_job_off = r_job - JOB_BRT_R;
    assign w_brt_idx = w_job_off[1:0];
    assign w_hv      = ch_of(r_ch, w_roles.hi);
    assign w_cv      = ch_of(r_ch, w_sat_idx);
    assign w_bv      = ch_of(r_ch, w_brt_idx);

    // Shared multiplier operand selection
    always_comb begin
        if (r_state == S_MUL_B) begin
            w_mul_a = {{(CFG_W-CH_W){1'b0}}, w_hv - w_cv};
            w_mul_b = r_x;
        end else if (!r_is_col) begin
            w_mul_a = HUE_SCALE;
            w_mul_b = r_x;
        end else if (r_job < JOB_BRT_R) begin
            w_mul_a = {{(CFG_W-CH_W){1'b0}}, w_hv};
            w_mul_b = r_width;
        end else begin
            w_mul_a = {{(CFG_W-CH_W){1'b0}}, w_bv};
            w_mul_b = r_y;
        end
    end
    assign w_prod = {{CFG_W{1'b0}}, w_mul_a} * {{CFG_W{1'b0}}, w_mul_b};

    assign w_div_ctl = '{start: (r_state == S_DIV_GO), wide: !r_is_col};

    hsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (r_acc),
        .i_den   (r_width),
        .o_sts   (w_div_sts),
        .o_quot  (w_quot)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_MUL_A;
            end
            S_MUL_A: begin
                n_state = (r_is_col && r_job < JOB_BRT_R) ? S_MUL_B : S_DIV_GO;
            end
            S_MUL_B:  n_state = S_SUB;
            S_SUB:    n_state = S_DIV_GO;
            S_DIV_GO: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (w_div_sts.done) begin
                    n_state = (!r_is_col || r_job == JOB_BRT_B) ? S_OUT : S_MUL_A;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and stored hue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= WIDTH_RST;
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_hue       <= HUE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WIDTH: r_width <= (i_cfg_data == '0) ? CFG_W'(1) : i_cfg_data;
                    CFG_ORG_X: r_org_x <= i_cfg_data;
                    CFG_ORG_Y: r_org_y <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_DIV_WAIT && w_div_sts.done && !r_is_col) begin
                r_hue <= hue_of(w_quot);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_is_col <= i_req_type;
            r_x      <= i_req_type ? w_x_col : w_x_hue;
            r_y      <= w_y;
            r_ch     <= r_hue;
            r_job    <= JOB_SAT_MID;
        end
        unique case (r_state)
            S_MUL_A: r_acc <= w_prod[NUM_W-1:0];
            S_MUL_B: r_prd <= w_prod[NUM_W-1:0];
            S_SUB:   r_acc <= r_acc - r_prd;
            S_DIV_WAIT: begin
                if (w_div_sts.done) begin
                    r_job <= r_job + 3'd1;
                    if (!r_is_col) begin
                        r_res <= hue_of(w_quot);
                    end else begin
                        case (r_job)
                            JOB_SAT_MID: r_ch  <= ch_put(r_ch, w_roles.mid, w_quot[CH_W-1:0]);
                            JOB_SAT_LO:  r_ch  <= ch_put(r_ch, w_roles.lo, w_quot[CH_W-1:0]);
                            default:     r_res <= ch_put(r_res, w_brt_idx, w_quot[CH_W-1:0]);
                        endcase
                    end
                end
            end
            default: ;
        endcase
        if (w_out_load) begin
            r_out_colour <= r_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_colour = r_out_colour;

    // Checks
    `HSP_CHK_NXT(a_busy_after_take, w_accept, !o_in_ready)
    `HSP_CHK_IMP(a_div_start_idle, w_div_ctl.start, !w_div_sts.busy)
    `HSP_CHK_IMP(a_div_done_waited, w_div_sts.done, r_state == S_DIV_WAIT)
    `HSP_CHK_IMP(a_result_from_out, $rose(r_out_valid), $past(r_state) == S_OUT)

endmodule
